>>> sv/sopm_pkg.sv
// shared observation pair matcher: package
// holds table geometry, command codes, request/result types and the slot helper
// no dependencies
package sopm_pkg;

	// table geometry
	localparam int NUM_POINTS  = 256;
	localparam int NUM_CAMERAS = 64;
	localparam int TABLE_DEPTH = NUM_POINTS * NUM_CAMERAS;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int PT_AW       = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
	localparam int CAM_AW      = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
	localparam int CNT_W       = $clog2(NUM_CAMERAS + 1);

	// observation entry: valid mark plus x and y bit patterns
	localparam int COORD_W = 64;
	localparam int ENTRY_W = COORD_W + 1;

	// match ratio register, unsigned q1.16
	localparam int          RATIO_W     = 17;
	localparam int          FRAC_W      = 16;
	localparam logic [16:0] RATIO_RESET = 17'd32768;
	localparam int          MUL_W       = CNT_W + RATIO_W;

	// command codes
	localparam logic [1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [1:0] CMD_COMPARE = 2'd2;
	localparam logic [1:0] CMD_CLEAR   = 2'd3;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  point_index;
		logic [5:0]  camera_index;
		logic [31:0] obs_x;
		logic [31:0] obs_y;
		logic [7:0]  other_point_index;
	} req_t;

	typedef struct packed {
		logic       is_match;
		logic [6:0] shared_count;
		logic [7:0] first_point;
		logic [7:0] second_point;
	} rsp_t;

	// flat table address of one (point, camera) entry
	function automatic logic [ADDR_W-1:0] slot_of(input int unsigned pt, input int unsigned cam);
		int unsigned s;
		s = pt * NUM_CAMERAS + cam;
		return s[ADDR_W-1:0];
	endfunction

endpackage

>>> sv/sopm_ram.sv
// shared observation pair matcher: generic simple dual-port ram
// one write port, one read port with registered read data
// no dependencies
module sopm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/shared_observation_pair_matcher.sv
// shared observation pair matcher: top level
// holds the sequencer, observation tables and match arithmetic
// depends on sopm_pkg and sopm_ram
//
// Requests are taken when start is high and busy is low. A load of cloud A
// passes a read state and then a write state, a load of cloud B writes in
// a single state, and a load with a point or camera out of range is dropped
// at once. A compare walks the camera entries of both points one per cycle
// through the two table memories, then passes a drain state and a done state
// before the registered done pulses; done is high for exactly one cycle with
// the result and the receiver cannot hold it off. A clear, and the start-up
// after reset, sweep every table entry one per cycle with busy high.
// The match ratio may be written whenever the block is idle, also during the
// sweep.
module shared_observation_pair_matcher
	import sopm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  req_t             request,
	output logic             busy,
	output logic             done,
	output rsp_t             result,
	input  logic             cfg_we,
	input  logic [RATIO_W-1:0] cfg_wdata
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SWEEP = 3'd1;
	localparam logic [2:0] ST_LDA_RD = 3'd2;
	localparam logic [2:0] ST_LDA_WR = 3'd3;
	localparam logic [2:0] ST_LDB   = 3'd4;
	localparam logic [2:0] ST_CMP   = 3'd5;
	localparam logic [2:0] ST_DRAIN = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(TABLE_DEPTH - 1);
	localparam logic [CAM_AW-1:0] CAM_LAST   = CAM_AW'(NUM_CAMERAS - 1);

	logic [2:0]         state_q;
	req_t               req_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [CAM_AW-1:0]  cam_q;
	logic               pair_ok_q;
	logic               pa_ok_q;
	logic               v_s1;
	logic [CNT_W-1:0]   shared_q;
	logic [CNT_W-1:0]   views_q;
	logic [MUL_W-1:0]   prod_q;
	logic               done_q;
	rsp_t               rsp_q;

	logic               accept;
	logic               ld_ok;
	logic               in_pa_ok;
	logic               in_pb_ok;
	logic [ADDR_W-1:0]  slot_ld;
	logic [ADDR_W-1:0]  raddr_a;
	logic [ADDR_W-1:0]  raddr_b;
	logic               we_a;
	logic               we_b;
	logic [ADDR_W-1:0]  waddr_t;
	logic [ENTRY_W-1:0] wdata_t;
	logic [ENTRY_W-1:0] rd_a;
	logic [ENTRY_W-1:0] rd_b;
	logic               we_v;
	logic [PT_AW-1:0]   waddr_v;
	logic [CNT_W-1:0]   wdata_v;
	logic [CNT_W-1:0]   rd_v;
	logic               hit;
	logic [CNT_W-1:0]   views_eff;
	logic [MUL_W-1:0]   lhs;

	assign accept   = start && !busy;
	assign in_pa_ok = int'(request.point_index) < NUM_POINTS;
	assign in_pb_ok = int'(request.other_point_index) < NUM_POINTS;
	assign ld_ok    = in_pa_ok && (int'(request.camera_index) < NUM_CAMERAS);

	// table addressing
	assign slot_ld = slot_of(32'(req_q.point_index), 32'(req_q.camera_index));
	assign raddr_a = (state_q == ST_CMP) ? slot_of(32'(req_q.point_index), 32'(cam_q)) : slot_ld;
	assign raddr_b = slot_of(32'(req_q.other_point_index), 32'(cam_q));

	// shared write path for both tables: sweep clears, loads write a valid entry
	assign we_a    = (state_q == ST_SWEEP) || (state_q == ST_LDA_WR);
	assign we_b    = (state_q == ST_SWEEP) || (state_q == ST_LDB);
	assign waddr_t = (state_q == ST_SWEEP) ? clr_q : slot_ld;
	assign wdata_t = (state_q == ST_SWEEP) ? '0 : {1'b1, req_q.obs_x, req_q.obs_y};

	// view counts: cleared by the sweep, bumped on a first cloud A load of an entry
	assign we_v    = ((state_q == ST_SWEEP) && (int'(clr_q) < NUM_POINTS))
		|| ((state_q == ST_LDA_WR) && !rd_a[COORD_W]);
	assign waddr_v = (state_q == ST_SWEEP) ? clr_q[PT_AW-1:0] : req_q.point_index[PT_AW-1:0];
	assign wdata_v = (state_q == ST_SWEEP) ? '0 : CNT_W'(rd_v + 1'b1);

	sopm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_tab_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr_t),
		.wdata (wdata_t),
		.raddr (raddr_a),
		.rdata (rd_a)
	);

	sopm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_tab_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr_t),
		.wdata (wdata_t),
		.raddr (raddr_b),
		.rdata (rd_b)
	);

	sopm_ram #(.WIDTH(CNT_W), .DEPTH(NUM_POINTS)) u_views (
		.clk   (clk),
		.we    (we_v),
		.waddr (waddr_v),
		.wdata (wdata_v),
		.raddr (req_q.point_index[PT_AW-1:0]),
		.rdata (rd_v)
	);

	// one camera entry compared per cycle
	assign hit = v_s1 && pair_ok_q && rd_a[COORD_W] && rd_b[COORD_W]
		&& (rd_a[COORD_W-1:0] == rd_b[COORD_W-1:0]);

	assign views_eff = pa_ok_q ? rd_v : '0;
	assign lhs       = MUL_W'({shared_q, {FRAC_W{1'b0}}});

	// ratio register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (cfg_we) begin
			ratio_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			clr_q   <= '0;
			cam_q   <= '0;
			v_s1    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			v_s1   <= (state_q == ST_CMP);
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (request.command)
							CMD_LOAD_A: state_q <= ld_ok ? ST_LDA_RD : ST_IDLE;
							CMD_LOAD_B: state_q <= ld_ok ? ST_LDB : ST_IDLE;
							CMD_COMPARE: begin
								state_q <= ST_CMP;
								cam_q   <= '0;
							end
							CMD_CLEAR: begin
								state_q <= ST_SWEEP;
								clr_q   <= '0;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SWEEP: begin
					clr_q <= ADDR_W'(clr_q + 1'b1);
					if (clr_q == SWEEP_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_LDA_RD: state_q <= ST_LDA_WR;
				ST_LDA_WR: state_q <= ST_IDLE;
				ST_LDB:    state_q <= ST_IDLE;
				ST_CMP: begin
					cam_q <= CAM_AW'(cam_q + 1'b1);
					if (cam_q == CAM_LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_DONE;
				ST_DONE: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request capture, count and match arithmetic
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= request;
			pa_ok_q   <= in_pa_ok;
			pair_ok_q <= in_pa_ok && in_pb_ok;
			shared_q  <= '0;
		end else if (hit) begin
			shared_q <= CNT_W'(shared_q + 1'b1);
		end
		if (state_q == ST_DRAIN) begin
			views_q <= views_eff;
			prod_q  <= MUL_W'(views_eff) * MUL_W'(ratio_q);
		end
		if (state_q == ST_DONE) begin
			rsp_q.is_match     <= lhs > prod_q;
			rsp_q.shared_count <= (int'(shared_q) > 127) ? 7'd127 : 7'(shared_q);
			rsp_q.first_point  <= req_q.point_index;
			rsp_q.second_point <= req_q.other_point_index;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = rsp_q;

	// a result strobe never lasts more than one cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held longer than one cycle");

	// a result is only given once the block is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result given while busy");

	// an accepted compare always starts the camera walk
	a_cmp_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && request.command == CMD_COMPARE) |=> (state_q == ST_CMP))
		else $error("compare request did not start the walk");

	// shared entries are a subset of cloud A's observations
	a_shared_le_views: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (shared_q <= views_q))
		else $error("shared count above cloud A view count");

	// no counted entry outside the compare walk
	a_hit_window: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> (state_q == ST_CMP || state_q == ST_DRAIN))
		else $error("entry counted outside compare");

endmodule

>>> sim/sopm_match_checker.sv
// shared observation pair matcher: result checker
// mirrors both observation tables and the ratio, predicts every compare and checks done results
// depends on sopm_pkg
module sopm_match_checker
	import sopm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  req_t               request,
	input  logic               busy,
	input  logic               done,
	input  rsp_t               result,
	input  logic               cfg_we,
	input  logic [RATIO_W-1:0] cfg_wdata,
	output int                 open_matches,
	output int                 mismatches
);

	// mirrored tables, ratio and outstanding compare results
	logic               seen_a  [TABLE_DEPTH];
	logic               seen_b  [TABLE_DEPTH];
	logic [COORD_W-1:0] obs_a   [TABLE_DEPTH];
	logic [COORD_W-1:0] obs_b   [TABLE_DEPTH];
	int unsigned        views_a [NUM_POINTS];
	logic [RATIO_W-1:0] ratio;
	rsp_t               expected_matches [$];
	rsp_t               want;
	int                 fail_total;

	// drop every valid mark and view count
	function automatic void drop_observations();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			seen_a[i] = 1'b0;
			seen_b[i] = 1'b0;
		end
		for (int p = 0; p < NUM_POINTS; p++) views_a[p] = 0;
	endfunction

	// write or replace one observation, out of range loads are dropped
	function automatic void store_observation(input req_t r);
		int unsigned slot;
		if (int'(r.point_index) >= NUM_POINTS || int'(r.camera_index) >= NUM_CAMERAS)
			return;
		slot = int'(r.point_index) * NUM_CAMERAS + int'(r.camera_index);
		if (r.command == CMD_LOAD_A) begin
			// a reload keeps the view count
			if (!seen_a[slot]) begin
				seen_a[slot] = 1'b1;
				views_a[int'(r.point_index)]++;
			end
			obs_a[slot] = {r.obs_x, r.obs_y};
		end else begin
			seen_b[slot] = 1'b1;
			obs_b[slot] = {r.obs_x, r.obs_y};
		end
	endfunction

	// count bit-identical observations and weigh them against the ratio
	function automatic rsp_t predict_pair_match(input req_t r);
		int unsigned     shared;
		int unsigned     sa;
		int unsigned     sb;
		longint unsigned views;
		longint unsigned lhs;
		longint unsigned rhs;
		rsp_t            m;
		shared = 0;
		views = 0;
		if (int'(r.point_index) < NUM_POINTS && int'(r.other_point_index) < NUM_POINTS) begin
			for (int c = 0; c < NUM_CAMERAS; c++) begin
				sa = int'(r.point_index) * NUM_CAMERAS + c;
				sb = int'(r.other_point_index) * NUM_CAMERAS + c;
				if (seen_a[sa] && seen_b[sb] && obs_a[sa] == obs_b[sb])
					shared++;
			end
		end
		if (int'(r.point_index) < NUM_POINTS)
			views = views_a[int'(r.point_index)];
		lhs = 64'(shared) << FRAC_W;
		rhs = views * 64'(ratio);
		m.is_match = (lhs > rhs);
		// the output count saturates, the test above uses the full count
		m.shared_count = (shared > 127) ? 7'd127 : 7'(shared);
		m.first_point = r.point_index;
		m.second_point = r.other_point_index;
		return m;
	endfunction

	// watch results, ratio writes and accepted requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_observations();
			ratio = RATIO_RESET;
			expected_matches.delete();
			fail_total = 0;
		end else begin
			// retire a finished compare
			if (done === 1'b1) begin
				if (expected_matches.size() == 0) begin
					fail_total++;
					$display("%0t: result with none expected, actual %0d/%0d/%0d/%0d",
						$time, result.is_match, result.shared_count,
						result.first_point, result.second_point);
				end else begin
					want = expected_matches.pop_front();
					if (result !== want) begin
						fail_total++;
						$display("%0t: match/count/first/second expected %0d/%0d/%0d/%0d actual %0d/%0d/%0d/%0d",
							$time, want.is_match, want.shared_count, want.first_point,
							want.second_point, result.is_match, result.shared_count,
							result.first_point, result.second_point);
					end
				end
			end
			// ratio write
			if (cfg_we === 1'b1)
				ratio = cfg_wdata;
			// accepted request
			if (start === 1'b1 && busy === 1'b0) begin
				case (request.command)
					CMD_LOAD_A, CMD_LOAD_B: store_observation(request);
					CMD_COMPARE: expected_matches.insert(expected_matches.size(),
						predict_pair_match(request));
					CMD_CLEAR: drop_observations();
					default: ;
				endcase
			end
		end
		open_matches <= expected_matches.size();
		mismatches <= fail_total;
	end

endmodule

>>> sim/tb_shared_observation_pair_matcher.sv
// shared observation pair matcher: testbench top
// drives requests and ratio writes, runs the watchdog and gives the verdict
// depends on sopm_pkg, shared_observation_pair_matcher and sopm_match_checker
module tb_shared_observation_pair_matcher
	import sopm_pkg::*;
();

	localparam int IDLE_LIMIT      = 100000;
	localparam int DIRECTED_ITEMS  = 22;
	localparam int ITEMS_PER_PHASE = 172;
	localparam int PHASES          = 6;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	req_t               request   = '0;
	logic               cfg_we    = 1'b0;
	logic [RATIO_W-1:0] cfg_wdata = '0;
	logic               busy;
	logic               done;
	rsp_t               result;
	int                 open_matches;
	int                 mismatches;
	int                 sent_total  = 0;
	int                 burst_left  = 1;
	int                 clears_left = 4;
	bit                 steady      = 1'b0;

	shared_observation_pair_matcher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.request  (request),
		.busy     (busy),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	sopm_match_checker match_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.request     (request),
		.busy        (busy),
		.done        (done),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.open_matches(open_matches),
		.mismatches  (mismatches)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// watchdog on cycles with no request accepted and no result
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				idle = 0;
			else
				idle++;
		end
		$display("watchdog: %0d cycles without progress", IDLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	function automatic req_t build_request(input logic [1:0] cmd, input logic [7:0] pa,
		input logic [5:0] cam, input logic [31:0] x, input logic [31:0] y,
		input logic [7:0] pb);
		req_t r;
		r.command = cmd;
		r.point_index = pa;
		r.camera_index = cam;
		r.obs_x = x;
		r.obs_y = y;
		r.other_point_index = pb;
		return r;
	endfunction

	// mostly a few crowded points, some extremes, some anywhere
	function automatic logic [7:0] pick_point();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 8'($urandom_range(0, 3));
			5: return 8'd255;
			6: return 8'd0;
			default: return 8'($urandom);
		endcase
	endfunction

	// signed zeros, two nan patterns, ordinary values and raw noise
	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'h8000_0000;
			2: return 32'h7fc0_0000;
			3: return 32'h3f80_0000;
			4: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// hand one request over, then idle between bursts
	task automatic issue(input req_t r);
		int gap;
		start <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		sent_total++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 20);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: gap = 0;
				4, 5, 6, 7: gap = $urandom_range(1, 8);
				8: gap = $urandom_range(9, 40);
				default: gap = $urandom_range(41, 90);
			endcase
			if (steady)
				gap = 0;
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// hold off until every compare has reported and the block is idle
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (open_matches != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	task automatic write_ratio(input logic [RATIO_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// load a point in both clouds, mostly alike, then compare the pair
	task automatic pair_scenario();
		logic [7:0]  pa;
		logic [7:0]  pb;
		logic [5:0]  cam;
		logic [31:0] x;
		logic [31:0] y;
		int          n;
		pa = pick_point();
		pb = ($urandom_range(0, 2) == 0) ? pa : pick_point();
		n = $urandom_range(1, 12);
		for (int k = 0; k < n; k++) begin
			cam = 6'($urandom_range(0, NUM_CAMERAS - 1));
			x = pick_coord();
			y = pick_coord();
			issue(build_request(CMD_LOAD_A, pa, cam, x, y, 8'($urandom)));
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5:
					issue(build_request(CMD_LOAD_B, pb, cam, x, y, 8'($urandom)));
				6: issue(build_request(CMD_LOAD_B, pb, cam,
					x ^ (32'd1 << $urandom_range(0, 31)), y, 8'($urandom)));
				7: issue(build_request(CMD_LOAD_B, pb, cam + 6'd1, x, y, 8'($urandom)));
				8: issue(build_request(CMD_LOAD_A, pa, cam, pick_coord(), pick_coord(),
					8'($urandom)));
				default: ;
			endcase
		end
		issue(build_request(CMD_COMPARE, pa, 6'($urandom), $urandom, $urandom, pb));
		if ($urandom_range(0, 3) == 0)
			issue(build_request(CMD_COMPARE, pa, 6'($urandom), $urandom, $urandom,
				pick_point()));
	endtask

	// one unrelated request, a rare clear among them
	task automatic noise_request();
		logic [1:0] cmd;
		cmd = 2'($urandom_range(0, 2));
		if (clears_left > 0 && $urandom_range(0, 59) == 0) begin
			cmd = CMD_CLEAR;
			clears_left--;
		end
		issue(build_request(cmd, pick_point(), 6'($urandom), $urandom, $urandom,
			pick_point()));
	endtask

	// stimulus and verdict
	initial begin : stimulus
		logic [RATIO_W-1:0] phase_ratio [PHASES];
		phase_ratio = '{17'd1, 17'd65535, 17'd0, 17'd65536, 17'd32768, 17'd0};
		phase_ratio[PHASES-1] = 17'($urandom_range(0, 65536));
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// empty tables, then a plain match at the reset ratio
		issue(build_request(CMD_COMPARE, 8'd0, 6'($urandom), $urandom, $urandom, 8'd0));
		issue(build_request(CMD_LOAD_A, 8'd0, 6'd0, 32'h3f80_0000, 32'h4000_0000, 8'd17));
		issue(build_request(CMD_LOAD_B, 8'd0, 6'd0, 32'h3f80_0000, 32'h4000_0000, 8'd200));
		issue(build_request(CMD_COMPARE, 8'd0, 6'd63, 32'hffff_ffff, 32'h0, 8'd0));
		// +0 against -0 on the last camera
		issue(build_request(CMD_LOAD_A, 8'd1, 6'd63, 32'h0000_0000, 32'h0000_0000, 8'd255));
		issue(build_request(CMD_LOAD_B, 8'd1, 6'd63, 32'h8000_0000, 32'h0000_0000, 8'd0));
		issue(build_request(CMD_COMPARE, 8'd1, 6'd0, 32'h0, 32'hffff_ffff, 8'd1));
		// identical nan patterns on the last point
		issue(build_request(CMD_LOAD_A, 8'd255, 6'd5, 32'h7fc0_0000, 32'h7fc0_0000, 8'd255));
		issue(build_request(CMD_LOAD_B, 8'd255, 6'd5, 32'h7fc0_0000, 32'h7fc0_0000, 8'd0));
		issue(build_request(CMD_COMPARE, 8'd255, 6'd5, $urandom, $urandom, 8'd255));
		// reload keeps the count, then a pair across different points
		issue(build_request(CMD_LOAD_A, 8'd0, 6'd0, 32'hffff_ffff, 32'hffff_ffff, 8'd3));
		issue(build_request(CMD_LOAD_B, 8'd2, 6'd0, 32'hffff_ffff, 32'hffff_ffff, 8'd3));
		issue(build_request(CMD_COMPARE, 8'd0, 6'd1, $urandom, $urandom, 8'd2));
		// share exactly at the ratio is no match
		issue(build_request(CMD_LOAD_A, 8'd0, 6'd1, 32'h1234_5678, 32'h9abc_def0, 8'd9));
		issue(build_request(CMD_COMPARE, 8'd0, 6'd2, $urandom, $urandom, 8'd2));
		// clear drops everything
		issue(build_request(CMD_CLEAR, 8'($urandom), 6'($urandom), $urandom, $urandom,
			8'($urandom)));
		issue(build_request(CMD_COMPARE, 8'd0, 6'd3, $urandom, $urandom, 8'd2));

		// zero ratio
		settle();
		write_ratio(17'd0);
		issue(build_request(CMD_LOAD_A, 8'd3, 6'd7, 32'h4049_0fdb, 32'hc2c8_0000, 8'd3));
		issue(build_request(CMD_COMPARE, 8'd3, 6'd7, $urandom, $urandom, 8'd3));
		issue(build_request(CMD_LOAD_B, 8'd3, 6'd7, 32'h4049_0fdb, 32'hc2c8_0000, 8'd3));
		issue(build_request(CMD_COMPARE, 8'd3, 6'd7, $urandom, $urandom, 8'd3));

		// ratio of one can never match
		settle();
		write_ratio(17'd65536);
		issue(build_request(CMD_COMPARE, 8'd3, 6'd7, $urandom, $urandom, 8'd3));

		// random phases, each under its own ratio
		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_ratio(phase_ratio[p]);
			steady = (p == 2);
			while (sent_total < DIRECTED_ITEMS + (p + 1) * ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 4) != 0)
					pair_scenario();
				else
					noise_request();
			end
		end

		settle();
		repeat (70) @(posedge clk);
		if (mismatches == 0 && open_matches == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatches, open_matches);
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/sopm_pkg.sv
sv/sopm_ram.sv
sv/shared_observation_pair_matcher.sv
sim/sopm_match_checker.sv
sim/tb_shared_observation_pair_matcher.sv
